>>> sv/keyed_device_registry_table_defines.svh
// ----------------------------------------------------------------------------
// Keyed device registry table: assertion macros
// Shared concurrent assertion forms used by the registry table modules.
// ----------------------------------------------------------------------------
`ifndef KEYED_DEVICE_REGISTRY_TABLE_DEFINES_SVH
`define KEYED_DEVICE_REGISTRY_TABLE_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define KDRT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication checked on every clock edge outside reset.
`define KDRT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |-> cons) else $error(msg);

`endif

>>> sv/kdrt_pkg.sv
// ----------------------------------------------------------------------------
// Keyed device registry table package
// Field widths, command codes, word types and the controller interface.
// ----------------------------------------------------------------------------
package kdrt_pkg;

	localparam int KEY_W    = 48;
	localparam int DATA_W   = 64;
	localparam int LIMIT_W  = 5;
	localparam int CNT_W    = 5;
	localparam int LIST_MAX = 16;

	// Command codes carried in the request word.
	typedef enum logic [1:0] {
		OP_SAVE   = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LIST   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	// Status codes of a result word.
	localparam logic ST_OK    = 1'b0;
	localparam logic ST_INVAL = 1'b1;

	typedef struct packed {
		op_t                cmd;
		logic [KEY_W-1:0]   key;
		logic [DATA_W-1:0]  entry_data;
		logic [LIMIT_W-1:0] list_limit;
	} req_t;

	typedef struct packed {
		logic               status;
		logic               entry_valid;
		logic [KEY_W-1:0]   entry_key;
		logic [DATA_W-1:0]  entry_payload;
		logic [CNT_W-1:0]   entry_count;
		logic               last;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic fill_clr;
		logic save_wr;
		logic shift_init;
		logic shift_wr;
		logic fill_dec;
		logic emit;
		logic rsp_load;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic hit;
		logic walk_done;
		logic list_empty;
	} dp_stat_t;

endpackage

>>> sv/kdrt_dpath.sv
// ----------------------------------------------------------------------------
// Keyed device registry table datapath
// Key and payload memories, scan pointer, compare stage, fill count and
// the result register.
// ----------------------------------------------------------------------------
`include "keyed_device_registry_table_defines.svh"

module kdrt_dpath import kdrt_pkg::*; #(
	parameter int TABLE_DEPTH  = 16,
	parameter int PAYLOAD_BITS = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	input  ctl_cmd_t cmd,
	output dp_stat_t stat,
	output logic     rsp_valid,
	output rsp_t     rsp
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int MW = (CW > CNT_W) ? CW : CNT_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	// Table storage, packed from slot zero upward.
	logic [KEY_W-1:0]        key_mem [TABLE_DEPTH];
	logic [PAYLOAD_BITS-1:0] pay_mem [TABLE_DEPTH];

	// Captured request.
	op_t                     op_q;
	logic [KEY_W-1:0]        key_q;
	logic [PAYLOAD_BITS-1:0] data_q;
	logic [CNT_W-1:0]        n_q;
	logic                    lim_zero_q;

	// Table and scan state.
	logic [CW-1:0]           fill_q;
	logic [CW-1:0]           ptr_q;
	logic                    rd_vld_s1;
	logic [CW-1:0]           rd_idx_s1;
	logic [KEY_W-1:0]        rd_key_s1;
	logic [PAYLOAD_BITS-1:0] rd_pay_s1;
	logic                    hit_q;
	logic [IW-1:0]           hit_idx_q;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;

	logic [MW-1:0]           bound;
	logic                    more;
	logic                    rd_en;
	logic                    key_match;
	logic [LIMIT_W-1:0]      lim_sat;
	logic [MW-1:0]           n_next;
	logic                    wr_key_en;
	logic                    wr_pay_en;
	logic [IW-1:0]           wr_addr;
	logic [KEY_W-1:0]        wr_key;
	logic [PAYLOAD_BITS-1:0] wr_pay;
	logic [DATA_W-1:0]       pay_ext;

	// Walk bound: list stops at its count, scans and shifts at the fill.
	assign bound     = (op_q == OP_LIST) ? MW'(n_q) : MW'(fill_q);
	assign more      = MW'(ptr_q) < bound;
	assign rd_en     = cmd.step && more;
	assign key_match = rd_vld_s1 && !hit_q && (rd_key_s1 == key_q);

	// Number of entries a list returns, from the saturated limit.
	assign lim_sat = (req.list_limit > LIMIT_W'(LIST_MAX)) ? LIMIT_W'(LIST_MAX)
		: req.list_limit;
	assign n_next  = (MW'(fill_q) < MW'(lim_sat)) ? MW'(fill_q) : MW'(lim_sat);

	assign stat.op         = op_q;
	assign stat.hit        = hit_q;
	assign stat.walk_done  = !more && !rd_vld_s1;
	assign stat.list_empty = (n_q == '0);

	// Write port: overwrite or append on save, move down by one on remove.
	always_comb begin
		wr_key_en = 1'b0;
		wr_pay_en = 1'b0;
		wr_addr   = '0;
		wr_key    = key_q;
		wr_pay    = data_q;
		if (cmd.save_wr) begin
			if (hit_q) begin
				wr_pay_en = 1'b1;
				wr_addr   = hit_idx_q;
			end else if (fill_q < DEPTH_C) begin
				wr_key_en = 1'b1;
				wr_pay_en = 1'b1;
				wr_addr   = IW'(fill_q);
			end
		end else if (cmd.shift_wr && rd_vld_s1) begin
			wr_key_en = 1'b1;
			wr_pay_en = 1'b1;
			wr_addr   = IW'(rd_idx_s1 - CW'(1));
			wr_key    = rd_key_s1;
			wr_pay    = rd_pay_s1;
		end
	end

	// Payload widened to the word field.
	always_comb begin
		pay_ext = '0;
		pay_ext[PAYLOAD_BITS-1:0] = rd_pay_s1;
	end

	// Memories: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_key_en) begin
			key_mem[wr_addr] <= wr_key;
		end
		if (wr_pay_en) begin
			pay_mem[wr_addr] <= wr_pay;
		end
		if (rd_en) begin
			rd_key_s1 <= key_mem[ptr_q[IW-1:0]];
			rd_pay_s1 <= pay_mem[ptr_q[IW-1:0]];
		end
	end

	// Control state of the table and the walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= OP_SAVE;
			fill_q      <= '0;
			ptr_q       <= '0;
			rd_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				op_q <= req.cmd;
			end
			if (cmd.fill_clr) begin
				fill_q <= '0;
			end else if (cmd.save_wr && !hit_q && (fill_q < DEPTH_C)) begin
				fill_q <= fill_q + CW'(1);
			end else if (cmd.fill_dec) begin
				fill_q <= fill_q - CW'(1);
			end
			if (cmd.load) begin
				ptr_q <= '0;
			end else if (cmd.shift_init) begin
				ptr_q <= CW'(hit_idx_q) + CW'(1);
			end else if (rd_en) begin
				ptr_q <= ptr_q + CW'(1);
			end
			if (cmd.load || cmd.shift_init) begin
				rd_vld_s1 <= 1'b0;
			end else begin
				rd_vld_s1 <= rd_en;
			end
			if (cmd.load) begin
				hit_q <= 1'b0;
			end else if (key_match) begin
				hit_q <= 1'b1;
			end
			rsp_valid_q <= cmd.rsp_load || (cmd.emit && rd_vld_s1);
		end
	end

	// Request capture, read index, match index and result word.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q      <= req.key;
			data_q     <= req.entry_data[PAYLOAD_BITS-1:0];
			n_q        <= CNT_W'(n_next);
			lim_zero_q <= (req.list_limit == '0);
		end
		if (rd_en) begin
			rd_idx_s1 <= ptr_q;
		end
		if (key_match) begin
			hit_idx_q <= rd_idx_s1[IW-1:0];
		end
		if (cmd.rsp_load) begin
			rsp_q.status        <= (op_q == OP_LIST && lim_zero_q) ? ST_INVAL : ST_OK;
			rsp_q.entry_valid   <= 1'b0;
			rsp_q.entry_key     <= '0;
			rsp_q.entry_payload <= '0;
			rsp_q.entry_count   <= (op_q == OP_LIST) ? n_q : CNT_W'(fill_q);
			rsp_q.last          <= 1'b1;
		end else if (cmd.emit && rd_vld_s1) begin
			rsp_q.status        <= ST_OK;
			rsp_q.entry_valid   <= 1'b1;
			rsp_q.entry_key     <= rd_key_s1;
			rsp_q.entry_payload <= pay_ext;
			rsp_q.entry_count   <= n_q;
			rsp_q.last          <= (MW'(rd_idx_s1) == (MW'(n_q) - MW'(1)));
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The fill never passes the table depth, and a remove drops it by one.
	`KDRT_ASSERT(a_fill_bound, fill_q <= DEPTH_C, "fill count above table depth")
	`KDRT_ASSERT(a_fill_dec, cmd.fill_dec |=> fill_q == $past(fill_q) - CW'(1), "bad remove fill")

endmodule

>>> sv/kdrt_ctrl.sv
// ----------------------------------------------------------------------------
// Keyed device registry table controller
// Sequences the scan, write, shift, list and response steps of a command.
// ----------------------------------------------------------------------------
`include "keyed_device_registry_table_defines.svh"

module kdrt_ctrl import kdrt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd,
	output logic     busy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_WRITE,
		S_SHIFT,
		S_LIST,
		S_RESP
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   busy_q;
	logic   scan_end;

	assign scan_end = stat.walk_done || stat.hit;

	// Next state and datapath commands.
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load   = 1'b1;
					state_next = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (stat.op)
					OP_SAVE, OP_REMOVE: begin
						state_next = S_SCAN;
					end
					OP_LIST: begin
						state_next = stat.list_empty ? S_RESP : S_LIST;
					end
					OP_CLEAR: begin
						cmd.fill_clr = 1'b1;
						state_next   = S_RESP;
					end
					default: begin
						state_next = S_RESP;
					end
				endcase
			end
			S_SCAN: begin
				if (!scan_end) begin
					cmd.step = 1'b1;
				end else if (stat.op == OP_SAVE) begin
					state_next = S_WRITE;
				end else if (stat.hit) begin
					cmd.shift_init = 1'b1;
					state_next     = S_SHIFT;
				end else begin
					state_next = S_RESP;
				end
			end
			S_WRITE: begin
				cmd.save_wr = 1'b1;
				state_next  = S_RESP;
			end
			S_SHIFT: begin
				cmd.step     = 1'b1;
				cmd.shift_wr = 1'b1;
				if (stat.walk_done) begin
					cmd.fill_dec = 1'b1;
					state_next   = S_RESP;
				end
			end
			S_LIST: begin
				cmd.step = 1'b1;
				cmd.emit = 1'b1;
				if (stat.walk_done) begin
					state_next = S_IDLE;
				end
			end
			S_RESP: begin
				cmd.rsp_load = 1'b1;
				state_next   = S_IDLE;
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	// State register and registered busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_next;
			busy_q  <= (state_next != S_IDLE);
		end
	end

	assign busy = busy_q;

	// An accepted word always enters dispatch, and busy tracks the state.
	`KDRT_ASSERT(a_accept, (state_q == S_IDLE && start) |=> state_q == S_DISPATCH, "no dispatch")
	`KDRT_ASSERT(a_busy, busy_q == (state_q != S_IDLE), "busy out of step with state")
	`KDRT_ASSERT_IMP(a_shift_hit, state_q == S_SHIFT, stat.hit, "shift without a match")

endmodule

>>> sv/keyed_device_registry_table.sv
// Save and remove scan one key per cycle; a remove that finds its key then shifts the
// later entries down. Clear, zero-limit and empty lists go straight to the result word.
// A list of n entries gives one result word a cycle. The next command is taken at the
// edge that ends a single result word; after a list, the block first returns to idle
// once its last word has gone. Words show for one cycle; the receiver cannot stall.
// Reset empties the table at once; no clearing pass runs over the memories.
// ----------------------------------------------------------------------------
// Keyed device registry table
// Packed table of device addresses with opaque payloads: save, remove, list
// and clear commands, one at a time.
// ----------------------------------------------------------------------------
module keyed_device_registry_table import kdrt_pkg::*; #(
	parameter int TABLE_DEPTH  = 16,
	parameter int PAYLOAD_BITS = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic rsp_valid,
	output rsp_t rsp
);

	ctl_cmd_t ctl_cmd;
	dp_stat_t dp_stat;

	// Command sequencer.
	kdrt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (dp_stat),
		.cmd    (ctl_cmd),
		.busy   (busy)
	);

	// Table storage and result path.
	kdrt_dpath #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (ctl_cmd),
		.stat      (dp_stat),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Keyed device registry table testbench
// Drives save, remove, list and clear commands through the start/busy
// handshake, keeps its own copy of the table to predict every result word,
// and checks each word against that prediction as it appears.
// ----------------------------------------------------------------------------
module tb_top;
	import kdrt_pkg::*;

	localparam int DEPTH      = 16;
	localparam int ERR_REPORT = 10;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic rsp_valid;
	rsp_t rsp;

	keyed_device_registry_table #(
		.TABLE_DEPTH (DEPTH),
		.PAYLOAD_BITS(DATA_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp      (rsp)
	);

	// Predicted table contents and the result words still to come.
	logic [KEY_W-1:0]  table_keys [DEPTH];
	logic [DATA_W-1:0] table_data [DEPTH];
	int                table_fill;
	rsp_t              pending_words[$];

	int n_sent;
	int n_words;
	int n_errors;
	int n_dropped;
	int n_overwrites;
	int n_removed;
	int n_list_words;
	int n_invalid;

	// Clock and reset.
	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Hard limit on the run.
	initial begin
		#2000000;
		$display("Timeout with %0d words still expected.", pending_words.size());
		$display("** keyed_device_registry_table: FAILED **");
		$finish;
	end

	function automatic logic [KEY_W-1:0] rand_key();
		logic [63:0] wide;
		wide = {$urandom(), $urandom()};
		return wide[KEY_W-1:0];
	endfunction

	function automatic logic [DATA_W-1:0] rand_data();
		return {$urandom(), $urandom()};
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int random_gap();
		int r;
		r = $urandom_range(99, 0);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(3, 1);
		else
			return $urandom_range(30, 8);
	endfunction

	function automatic rsp_t make_word(logic st, logic vld, logic [KEY_W-1:0] k,
			logic [DATA_W-1:0] d, int cnt, logic lst);
		rsp_t w;
		w.status        = st;
		w.entry_valid   = vld;
		w.entry_key     = k;
		w.entry_payload = d;
		w.entry_count   = cnt[CNT_W-1:0];
		w.last          = lst;
		return w;
	endfunction

	// Apply one accepted command to the predicted table and queue its words.
	task automatic apply_command(input req_t r);
		int hit;
		int lim;
		int n;
		hit = -1;
		for (int i = 0; i < table_fill; i++) begin
			if (hit < 0 && table_keys[i] == r.key)
				hit = i;
		end
		case (r.cmd)
			OP_SAVE: begin
				if (hit >= 0) begin
					table_data[hit] = r.entry_data;
					n_overwrites++;
				end else if (table_fill < DEPTH) begin
					table_keys[table_fill] = r.key;
					table_data[table_fill] = r.entry_data;
					table_fill++;
				end else begin
					n_dropped++;
				end
				pending_words.push_back(make_word(ST_OK, 1'b0, '0, '0, table_fill, 1'b1));
			end
			OP_REMOVE: begin
				if (hit >= 0) begin
					for (int i = hit; i + 1 < table_fill; i++) begin
						table_keys[i] = table_keys[i + 1];
						table_data[i] = table_data[i + 1];
					end
					table_fill--;
					n_removed++;
				end
				pending_words.push_back(make_word(ST_OK, 1'b0, '0, '0, table_fill, 1'b1));
			end
			OP_LIST: begin
				lim = int'(r.list_limit);
				if (lim == 0) begin
					n_invalid++;
					pending_words.push_back(make_word(ST_INVAL, 1'b0, '0, '0, 0, 1'b1));
				end else begin
					if (lim > LIST_MAX)
						lim = LIST_MAX;
					n = (table_fill < lim) ? table_fill : lim;
					if (n == 0)
						pending_words.push_back(make_word(ST_OK, 1'b0, '0, '0, 0, 1'b1));
					for (int i = 0; i < n; i++) begin
						pending_words.push_back(make_word(ST_OK, 1'b1, table_keys[i],
							table_data[i], n, (i + 1 == n)));
						n_list_words++;
					end
				end
			end
			OP_CLEAR: begin
				table_fill = 0;
				pending_words.push_back(make_word(ST_OK, 1'b0, '0, '0, 0, 1'b1));
			end
		endcase
	endtask

	// Present one command word and hold it until the block takes it.
	task automatic send_word(input op_t op, input logic [KEY_W-1:0] k,
			input logic [DATA_W-1:0] d, input logic [LIMIT_W-1:0] lim);
		req_t r;
		r.cmd        = op;
		r.key        = k;
		r.entry_data = d;
		r.list_limit = lim;
		@(negedge clk);
		start <= 1'b1;
		req   <= r;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		apply_command(r);
		n_sent++;
	endtask

	// Drop start for a number of cycles, with junk on the request lines.
	task automatic pause_sender(input int cycles);
		logic [127:0] junk;
		if (cycles > 0) begin
			junk = {$urandom(), $urandom(), $urandom(), $urandom()};
			@(negedge clk);
			start <= 1'b0;
			req   <= junk[$bits(req_t)-1:0];
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	// Hold off until every predicted word has come back.
	task automatic wait_drained();
		pause_sender(1);
		wait (pending_words.size() == 0);
		@(posedge clk);
	endtask

	// Result checker: one word per strobe, compared with the oldest prediction.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid === 1'b1) begin
			n_words++;
			if (pending_words.size() == 0) begin
				n_errors++;
				if (n_errors <= ERR_REPORT)
					$display("Unexpected result word %p at %0t", rsp, $realtime);
			end else begin
				want = pending_words.pop_front();
				if (rsp.status !== want.status || rsp.entry_valid !== want.entry_valid ||
						rsp.entry_key !== want.entry_key ||
						rsp.entry_payload !== want.entry_payload ||
						rsp.entry_count !== want.entry_count || rsp.last !== want.last) begin
					n_errors++;
					if (n_errors <= ERR_REPORT) begin
						$display("Mismatch at %0t:", $realtime);
						$display("  expected st=%0d vld=%0d key=%h data=%h cnt=%0d last=%0d",
							want.status, want.entry_valid, want.entry_key,
							want.entry_payload, want.entry_count, want.last);
						$display("  actual   st=%0d vld=%0d key=%h data=%h cnt=%0d last=%0d",
							rsp.status, rsp.entry_valid, rsp.entry_key,
							rsp.entry_payload, rsp.entry_count, rsp.last);
					end
				end
			end
		end
	end

	// Corner cases: empty table, zero and oversized limits, extreme keys and
	// payloads, overwrite, removal at the head, middle and tail, missing keys.
	task automatic test_directed();
		logic [KEY_W-1:0]  k_ones;
		logic [KEY_W-1:0]  k_alt;
		logic [DATA_W-1:0] d_ones;
		k_ones = '1;
		k_alt  = {(KEY_W/2){2'b01}};
		d_ones = '1;
		send_word(OP_LIST, rand_key(), rand_data(), 5'd5);
		send_word(OP_LIST, rand_key(), rand_data(), 5'd0);
		send_word(OP_SAVE, '0, '0, 5'd0);
		send_word(OP_SAVE, k_ones, d_ones, 5'd31);
		pause_sender(random_gap());
		send_word(OP_SAVE, k_alt, {(DATA_W/2){2'b10}}, LIMIT_W'($urandom_range(31, 0)));
		send_word(OP_SAVE, k_ones, 64'h0123_4567_89ab_cdef, 5'd0);
		send_word(OP_LIST, '0, '0, 5'd31);
		send_word(OP_REMOVE, 48'h0000_0000_1234, rand_data(), 5'd0);
		send_word(OP_REMOVE, '0, rand_data(), 5'd0);
		send_word(OP_LIST, rand_key(), rand_data(), 5'd16);
		pause_sender(random_gap());
		send_word(OP_SAVE, '0, rand_data(), 5'd17);
		send_word(OP_REMOVE, k_alt, d_ones, 5'd0);
		send_word(OP_LIST, rand_key(), rand_data(), 5'd1);
		send_word(OP_REMOVE, k_ones, '0, 5'd0);
		send_word(OP_REMOVE, '0, '0, 5'd0);
		send_word(OP_REMOVE, k_ones, d_ones, 5'd31);
		send_word(OP_SAVE, rand_key(), rand_data(), 5'd2);
		send_word(OP_CLEAR, rand_key(), rand_data(), 5'd2);
		send_word(OP_LIST, rand_key(), rand_data(), 5'd2);
		send_word(OP_CLEAR, k_ones, d_ones, 5'd31);
		wait_drained();
	endtask

	// Fill the table to the top, push past it, overwrite while full, then
	// punch holes and refill.
	task automatic test_full_table();
		logic [KEY_W-1:0] keys [DEPTH];
		send_word(OP_CLEAR, rand_key(), rand_data(), LIMIT_W'($urandom_range(31, 0)));
		for (int i = 0; i < DEPTH; i++) begin
			keys[i] = rand_key();
			send_word(OP_SAVE, keys[i], rand_data(), LIMIT_W'($urandom_range(31, 0)));
			pause_sender(random_gap());
		end
		send_word(OP_SAVE, rand_key(), rand_data(), 5'd0);
		send_word(OP_SAVE, keys[7], rand_data(), 5'd0);
		send_word(OP_LIST, rand_key(), rand_data(), 5'd16);
		send_word(OP_LIST, rand_key(), rand_data(), LIMIT_W'($urandom_range(31, 17)));
		send_word(OP_REMOVE, keys[DEPTH-1], rand_data(), 5'd0);
		send_word(OP_REMOVE, keys[0], rand_data(), 5'd0);
		send_word(OP_SAVE, keys[0] ^ (48'd1 << $urandom_range(KEY_W-1, 0)), rand_data(), 5'd0);
		send_word(OP_LIST, rand_key(), rand_data(), LIMIT_W'($urandom_range(16, 1)));
		wait_drained();
	endtask

	// Random traffic over a small pool of keys so that hits, overwrites,
	// removals and full-table drops keep happening; some keys are noise.
	task automatic test_random_mix(input int items);
		logic [KEY_W-1:0]  pool [20];
		logic [KEY_W-1:0]  k;
		logic [LIMIT_W-1:0] lim;
		op_t               op;
		int                r;
		int                save_pct;
		int                remove_pct;
		int                lr;
		pool[0] = '0;
		pool[1] = '1;
		for (int i = 2; i < 20; i++)
			pool[i] = rand_key();
		// Neighbors one bit apart stress the key compare.
		pool[3] = pool[2] ^ (48'd1 << $urandom_range(KEY_W-1, 0));
		pool[5] = pool[4] ^ (48'd1 << $urandom_range(KEY_W-1, 0));
		for (int i = 0; i < items; i++) begin
			// Alternate between filling phases and draining phases.
			if ((i / 40) % 2 == 0) begin
				save_pct   = 60;
				remove_pct = 15;
			end else begin
				save_pct   = 30;
				remove_pct = 40;
			end
			r = $urandom_range(99, 0);
			if (r < save_pct)
				op = OP_SAVE;
			else if (r < save_pct + remove_pct)
				op = OP_REMOVE;
			else if (r < 97)
				op = OP_LIST;
			else
				op = OP_CLEAR;
			k = ($urandom_range(9, 0) == 0) ? rand_key() : pool[$urandom_range(19, 0)];
			lr = $urandom_range(99, 0);
			if (lr < 10)
				lim = '0;
			else if (lr < 25)
				lim = LIMIT_W'($urandom_range(31, 17));
			else
				lim = LIMIT_W'($urandom_range(16, 1));
			send_word(op, k, rand_data(), lim);
			if (i % 45 == 44)
				wait_drained();
			else if ((i / 25) % 3 != 1)
				pause_sender(random_gap());
		end
		wait_drained();
	endtask

	// Test sequence.
	initial begin
		int spin;
		table_fill   = 0;
		n_sent       = 0;
		n_words      = 0;
		n_errors     = 0;
		n_dropped    = 0;
		n_overwrites = 0;
		n_removed    = 0;
		n_list_words = 0;
		n_invalid    = 0;
		@(posedge arst_n);
		test_directed();
		test_full_table();
		test_random_mix(170);
		pause_sender(1);
		spin = 0;
		while (pending_words.size() != 0 && spin < 5000) begin
			@(posedge clk);
			spin++;
		end
		if (pending_words.size() != 0) begin
			n_errors++;
			$display("%0d expected words never arrived.", pending_words.size());
		end
		repeat (30) @(posedge clk);
		$display("Sent %0d commands and checked %0d result words (%0d listed entries).",
			n_sent, n_words, n_list_words);
		$display("Overwrites %0d, removals %0d, drops on a full table %0d, zero limits %0d.",
			n_overwrites, n_removed, n_dropped, n_invalid);
		if (n_errors == 0)
			$display("** keyed_device_registry_table: PASSED **");
		else
			$display("** keyed_device_registry_table: FAILED **");
		$finish;
	end

endmodule
